[rtl/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, field widths and codes of the paged frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int REQ_TYPE_W   = 2;
	localparam int PROC_ID_W    = 16;
	localparam int SIZE_W       = 20;
	localparam int PAGE_NUM_W   = 6;
	localparam int STATUS_W     = 2;
	localparam int FRAME_NUM_W  = 8;
	localparam int PAGE_SIZE_W  = 13;
	localparam int FRAME_CNT_W  = 9;
	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 13;
	// ceil numerator: size + page_size - 1
	localparam int DIV_NUM_W    = SIZE_W + 1;

	localparam logic [REQ_TYPE_W-1:0] REQ_CREATE = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_RESIZE = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_PROC    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_PAGE    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd3;

	localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_SIZE   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_COUNT = 2'd1;

	localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RST   = 13'd32;
	localparam logic [FRAME_CNT_W-1:0] FRAME_COUNT_RST = 9'd256;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_DISPATCH,
		S_DIV,
		S_GROW,
		S_SHRINK,
		S_SH_WAIT,
		S_LK_WAIT,
		S_DONE
	} pfa_state_t;

endpackage

[rtl/pfa_req_if.sv]
// ----------------------------------------------------------------------------
// pfa_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface pfa_req_if import pfa_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [PROC_ID_W-1:0]  proc_id;
	logic [SIZE_W-1:0]     new_size;
	logic [PAGE_NUM_W-1:0] page_number;

	modport source (output valid, req_type, proc_id, new_size, page_number, input ready);
	modport sink   (input valid, req_type, proc_id, new_size, page_number, output ready);
endinterface

[rtl/pfa_rsp_if.sv]
// ----------------------------------------------------------------------------
// pfa_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface pfa_rsp_if import pfa_pkg::*; ;
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic                   out_of_memory;
	logic [FRAME_NUM_W-1:0] frame_number;

	modport source (output valid, status, out_of_memory, frame_number, input ready);
	modport sink   (input valid, status, out_of_memory, frame_number, output ready);
endinterface

[rtl/pfa_cfg_if.sv]
// ----------------------------------------------------------------------------
// pfa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pfa_cfg_if import pfa_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/paged_frame_allocator_core.sv]
// ----------------------------------------------------------------------------
// paged_frame_allocator_core
// Process table, per-process page tables and frame bitmap allocator.
// ----------------------------------------------------------------------------
// One request at a time. A request is taken in an idle cycle, then walks the
// process table one slot a cycle, then: create and unknown pids go from the
// dispatch state to the result state. Lookup reads the page table RAM in a
// wait state, which an unmapped page skips. Resize takes a dispatch cycle and
// waits for the divider. It then grows by scanning the frame bitmap one frame
// a cycle (at most min(frame_count, NUM_FRAMES) frames), shrinks through a
// shrink and a wait state per freed page, or keeps its size, and ends in the
// result state. Remove frees its pages the same way, after its dispatch cycle
// and before its result state. A finished result sits in the output register,
// so the next request is taken while it waits. No clearing pass after reset.
module paged_frame_allocator_core import pfa_pkg::*; #(
	parameter int MAX_PROCS  = 16,
	parameter int MAX_PAGES  = 64,
	parameter int NUM_FRAMES = 256
) (
	input  logic   clk,
	input  logic   arst_n,
	pfa_req_if.sink   req,
	pfa_rsp_if.source rsp,
	pfa_cfg_if.sink   cfg
);
	localparam int SLOT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int PCNT_W = $clog2(MAX_PAGES + 1);
	localparam int FRM_W  = $clog2(NUM_FRAMES);
	localparam int FCNT_W = $clog2(NUM_FRAMES + 1);
	localparam int DEPTH  = MAX_PROCS * MAX_PAGES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	pfa_state_t state_q, state_d;

	logic [PAGE_SIZE_W-1:0] page_size_q;
	logic [FRAME_CNT_W-1:0] frame_count_q;

	logic                   proc_valid_q [MAX_PROCS];
	logic [PROC_ID_W-1:0]   proc_pid_q   [MAX_PROCS];
	logic [SIZE_W-1:0]      proc_bytes_q [MAX_PROCS];
	logic [PCNT_W-1:0]      proc_pages_q [MAX_PROCS];
	logic [NUM_FRAMES-1:0]  frame_used_q;

	logic [REQ_TYPE_W-1:0]  req_type_q;
	logic [PROC_ID_W-1:0]   pid_q;
	logic [SIZE_W-1:0]      size_q;
	logic [PAGE_NUM_W-1:0]  page_q;
	logic [SLOT_W-1:0]      scan_slot_q, slot_q, free_slot_q;
	logic                   found_q, free_ok_q;
	logic [PCNT_W-1:0]      want_q, keep_q;
	logic [FCNT_W-1:0]      scan_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   oom_q;
	logic [FRAME_NUM_W-1:0] frame_q;

	logic                   rsp_valid_q;
	logic [STATUS_W-1:0]    rsp_status_q;
	logic                   rsp_oom_q;
	logic [FRAME_NUM_W-1:0] rsp_frame_q;

	logic                   div_start, div_done;
	logic [DIV_NUM_W-1:0]   div_num, div_quot;
	logic [PAGE_SIZE_W-1:0] ps_eff;
	logic                   capped;
	logic [PCNT_W-1:0]      want_calc;

	logic [FCNT_W-1:0]      lim;
	logic [PCNT_W-1:0]      cur_pages;
	logic [SIZE_W-1:0]      cur_bytes;
	logic                   pid_hit, last_slot, lk_ok, shr_more, rsp_free;
	logic                   grow_full, grow_out, grow_take, accept;

	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
	logic [FRM_W-1:0]       ram_wdata, ram_rdata;

	function automatic logic [ADDR_W-1:0] pt_addr(input int s, input int p);
		return ADDR_W'(s * MAX_PAGES + p);
	endfunction

	assign accept    = req.valid && req.ready;
	assign cur_pages = proc_pages_q[slot_q];
	assign cur_bytes = proc_bytes_q[slot_q];
	assign pid_hit   = proc_valid_q[scan_slot_q] && (proc_pid_q[scan_slot_q] == pid_q);
	assign last_slot = scan_slot_q == SLOT_W'(MAX_PROCS - 1);
	assign lk_ok     = (PCNT_W'(page_q) < cur_pages || 32'(page_q) >= (1 << PCNT_W))
		&& 32'(page_q) < 32'(cur_pages) && 32'(page_q) < MAX_PAGES;
	assign shr_more  = cur_pages > keep_q;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign grow_full = cur_pages >= want_q;
	assign grow_out  = scan_q >= lim;
	assign grow_take = !grow_full && !grow_out && !frame_used_q[scan_q[FRM_W-1:0]];

	always_comb begin
		if (32'(frame_count_q) > NUM_FRAMES) begin
			lim = FCNT_W'(NUM_FRAMES);
		end else begin
			lim = FCNT_W'(frame_count_q);
		end
	end

	// ceil(size / page_size) on the divider; zero page size acts as one
	assign ps_eff    = (page_size_q == '0) ? PAGE_SIZE_W'(1) : page_size_q;
	assign div_num   = DIV_NUM_W'(size_q) + DIV_NUM_W'(ps_eff) - DIV_NUM_W'(1);
	assign div_start = (state_q == S_DISPATCH) && found_q && (req_type_q == REQ_RESIZE);
	assign capped    = div_quot > DIV_NUM_W'(MAX_PAGES);
	assign want_calc = capped ? PCNT_W'(MAX_PAGES) : PCNT_W'(div_quot);

	pfa_div #(.NUM_W(DIV_NUM_W), .DEN_W(PAGE_SIZE_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (ps_eff),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign ram_we    = (state_q == S_GROW) && grow_take;
	assign ram_waddr = pt_addr(int'(slot_q), int'(cur_pages));
	assign ram_wdata = scan_q[FRM_W-1:0];
	assign ram_raddr = (state_q == S_DISPATCH) ? pt_addr(int'(slot_q), int'(page_q))
		: pt_addr(int'(slot_q), int'(cur_pages) - 1);

	pfa_ram #(.WIDTH(FRM_W), .DEPTH(DEPTH)) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (last_slot) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (req_type_q == REQ_CREATE || !found_q) begin
					state_d = S_DONE;
				end else begin
					case (req_type_q)
						REQ_RESIZE: state_d = S_DIV;
						REQ_LOOKUP: state_d = lk_ok ? S_LK_WAIT : S_DONE;
						default:    state_d = S_SHRINK;
					endcase
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (size_q > cur_bytes) state_d = S_GROW;
					else if (size_q < cur_bytes) state_d = S_SHRINK;
					else state_d = S_DONE;
				end
			end
			S_GROW: begin
				if (grow_full || grow_out) state_d = S_DONE;
			end
			S_SHRINK: begin
				state_d = shr_more ? S_SH_WAIT : S_DONE;
			end
			S_SH_WAIT: state_d = S_SHRINK;
			S_LK_WAIT: state_d = S_DONE;
			S_DONE: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q   <= PAGE_SIZE_RST;
			frame_count_q <= FRAME_COUNT_RST;
			frame_used_q  <= '0;
			rsp_valid_q   <= 1'b0;
			for (int i = 0; i < MAX_PROCS; i++) proc_valid_q[i] <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.addr == CFG_PAGE_SIZE) page_size_q <= cfg.data;
				if (cfg.addr == CFG_FRAME_COUNT) frame_count_q <= cfg.data[FRAME_CNT_W-1:0];
			end
			if (state_q == S_DISPATCH && req_type_q == REQ_CREATE && !found_q && free_ok_q) begin
				proc_valid_q[free_slot_q] <= 1'b1;
			end
			if (state_q == S_SHRINK && !shr_more && req_type_q == REQ_REMOVE) begin
				proc_valid_q[slot_q] <= 1'b0;
			end
			if (state_q == S_GROW && grow_take) begin
				frame_used_q[scan_q[FRM_W-1:0]] <= 1'b1;
			end
			if (state_q == S_SH_WAIT) begin
				frame_used_q[ram_rdata] <= 1'b0;
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_type_q  <= req.req_type;
					pid_q       <= req.proc_id;
					size_q      <= req.new_size;
					page_q      <= req.page_number;
					scan_slot_q <= '0;
					found_q     <= 1'b0;
					free_ok_q   <= 1'b0;
					status_q    <= ST_OK;
					oom_q       <= 1'b0;
					frame_q     <= '0;
				end
			end
			S_SEARCH: begin
				if (pid_hit) begin
					found_q <= 1'b1;
					slot_q  <= scan_slot_q;
				end
				if (!proc_valid_q[scan_slot_q] && !free_ok_q) begin
					free_ok_q   <= 1'b1;
					free_slot_q <= scan_slot_q;
				end
				scan_slot_q <= SLOT_W'(scan_slot_q + 1'b1);
			end
			S_DISPATCH: begin
				scan_q <= '0;
				keep_q <= '0;
				if (req_type_q == REQ_CREATE) begin
					if (!found_q) begin
						if (!free_ok_q) begin
							status_q <= ST_TABLE_FULL;
						end else begin
							proc_pid_q[free_slot_q]   <= pid_q;
							proc_bytes_q[free_slot_q] <= '0;
							proc_pages_q[free_slot_q] <= '0;
						end
					end
				end else if (!found_q) begin
					status_q <= ST_NO_PROC;
				end else if (req_type_q == REQ_LOOKUP && !lk_ok) begin
					status_q <= ST_NO_PAGE;
				end
			end
			S_DIV: begin
				if (div_done) begin
					want_q <= want_calc;
					if (size_q > cur_bytes) begin
						proc_bytes_q[slot_q] <= size_q;
						oom_q                <= capped;
					end else if (size_q < cur_bytes) begin
						proc_bytes_q[slot_q] <= size_q;
						keep_q               <= want_calc;
					end
				end
			end
			S_GROW: begin
				if (!grow_full) begin
					if (grow_out) begin
						oom_q <= 1'b1;
					end else begin
						scan_q <= scan_q + FCNT_W'(1);
						if (grow_take) proc_pages_q[slot_q] <= cur_pages + PCNT_W'(1);
					end
				end
			end
			S_SH_WAIT: begin
				proc_pages_q[slot_q] <= cur_pages - PCNT_W'(1);
			end
			S_LK_WAIT: begin
				frame_q <= FRAME_NUM_W'(ram_rdata);
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_status_q <= status_q;
					rsp_oom_q    <= oom_q;
					rsp_frame_q  <= frame_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready         = state_q == S_IDLE;
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.out_of_memory = rsp_oom_q;
	assign rsp.frame_number  = rsp_frame_q;

	// a frame being returned must have been handed out
	a_free_used: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SH_WAIT |-> frame_used_q[ram_rdata])
		else $error("freeing a frame that is not marked used");

	// frame scan never runs past the usable frame range
	a_scan_lim: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GROW |-> scan_q <= lim)
		else $error("frame scan beyond limit");

	// growth never exceeds the page table of a process
	a_pages_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GROW |-> 32'(cur_pages) <= MAX_PAGES)
		else $error("page count above table size");

	// a result is loaded only while the output register can take it
	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && !rsp.ready) |=> state_q == S_DONE)
		else $error("result dropped while output stalled");
endmodule

[rtl/pfa_ram.sv]
// ----------------------------------------------------------------------------
// pfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/pfa_div.sv]
// ----------------------------------------------------------------------------
// pfa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfa_div import pfa_pkg::*; #(
	parameter int NUM_W = DIV_NUM_W,
	parameter int DEN_W = PAGE_SIZE_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], fits};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
